/* src/rfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types for the rational fraction ALU: command codes and the
// payload structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package rfa_pkg;

  // command codes carried in tuser
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_NEG = 4'd4,
    CMD_EQ  = 4'd5,
    CMD_NE  = 4'd6,
    CMD_LT  = 4'd7,
    CMD_GE  = 4'd8,
    CMD_GT  = 4'd9,
    CMD_LE  = 4'd10
  } cmd_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned ProdW = 2 * WordW;

  // operands as captured at the input
  typedef struct packed {
    cmd_e                    cmd;
    logic signed [WordW-1:0] a_num;
    logic signed [WordW-1:0] a_den;
    logic signed [WordW-1:0] b_num;
    logic signed [WordW-1:0] b_den;
  } op_t;

  // registered products and shortcut terms
  typedef struct packed {
    cmd_e                    cmd;
    logic signed [ProdW-1:0] p_a;       // a_num * b_den, or a_num * b_num for mul
    logic signed [ProdW-1:0] p_b;       // b_num * a_den
    logic [WordW-1:0]        p_den;     // low word of a_den * b_den
    logic [WordW-1:0]        short_num; // equal-denominator sum/diff, or negation
    logic [WordW-1:0]        a_den;
    logic                    den_eq;
    logic                    num_eq;
  } prod_t;

  // result before denominator fix-up
  typedef struct packed {
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
    logic             cmp;
    logic             arith;
  } eval_t;

  // final result word
  typedef struct packed {
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
    logic             cmp;
    logic             den_zero;
  } res_t;

endpackage

/* src/rfa_mult.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_mult
// Multiply stage: forms the three cross products and the shortcut
// numerator for equal denominators and negation, then registers them.
// ----------------------------------------------------------------------------
module rfa_mult (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire rfa_pkg::op_t   op_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output rfa_pkg::prod_t     prod_o
);

  logic                  vld_q;
  logic                  en;
  rfa_pkg::prod_t        prod_d, prod_q;
  logic signed [31:0]    a_mult;

  // stage advances when empty or when the next stage takes its content
  assign en      = !vld_q || ready_i;
  assign ready_o = en;

  // second operand of the first product depends on the command
  assign a_mult = (op_i.cmd == rfa_pkg::CMD_MUL) ? op_i.b_num : op_i.b_den;

  // products and shortcut terms
  always_comb begin
    prod_d.cmd    = op_i.cmd;
    prod_d.p_a    = 64'(op_i.a_num) * 64'(a_mult);
    prod_d.p_b    = 64'(op_i.b_num) * 64'(op_i.a_den);
    prod_d.p_den  = 32'(op_i.a_den * op_i.b_den);
    prod_d.a_den  = op_i.a_den;
    prod_d.den_eq = (op_i.a_den == op_i.b_den);
    prod_d.num_eq = (op_i.a_num == op_i.b_num);
    unique case (op_i.cmd)
      rfa_pkg::CMD_SUB: prod_d.short_num = op_i.a_num - op_i.b_num;
      rfa_pkg::CMD_NEG: prod_d.short_num = 32'd0 - op_i.a_num;
      default:          prod_d.short_num = op_i.a_num + op_i.b_num;
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = vld_q;
  assign prod_o  = prod_q;

endmodule
`default_nettype wire

/* src/rfa_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_eval
// Evaluate stage: combines the products into the result fraction or the
// compare outcome from the exact 64-bit cross products.
// ----------------------------------------------------------------------------
module rfa_eval (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire rfa_pkg::prod_t  prod_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rfa_pkg::eval_t      eval_o
);

  logic           vld_q;
  logic           en;
  logic           lt;
  logic           gt;
  logic           eq;
  logic [31:0]    pa_lo;
  logic [31:0]    pb_lo;
  rfa_pkg::eval_t eval_d, eval_q;

  assign en      = !vld_q || ready_i;
  assign ready_o = en;

  assign pa_lo = prod_i.p_a[31:0];
  assign pb_lo = prod_i.p_b[31:0];

  // exact compares on the signed cross products
  assign lt = (prod_i.p_a < prod_i.p_b);
  assign gt = (prod_i.p_a > prod_i.p_b);
  assign eq = prod_i.den_eq ? prod_i.num_eq : (prod_i.p_a == prod_i.p_b);

  // result select per command
  always_comb begin
    eval_d.num   = '0;
    eval_d.den   = 32'd1;
    eval_d.cmp   = 1'b0;
    eval_d.arith = 1'b0;
    unique case (prod_i.cmd)
      rfa_pkg::CMD_ADD: begin
        eval_d.arith = 1'b1;
        eval_d.num   = prod_i.den_eq ? prod_i.short_num : pa_lo + pb_lo;
        eval_d.den   = prod_i.den_eq ? prod_i.a_den : prod_i.p_den;
      end
      rfa_pkg::CMD_SUB: begin
        eval_d.arith = 1'b1;
        eval_d.num   = prod_i.den_eq ? prod_i.short_num : pa_lo - pb_lo;
        eval_d.den   = prod_i.den_eq ? prod_i.a_den : prod_i.p_den;
      end
      rfa_pkg::CMD_MUL: begin
        eval_d.arith = 1'b1;
        eval_d.num   = pa_lo;
        eval_d.den   = prod_i.p_den;
      end
      rfa_pkg::CMD_DIV: begin
        eval_d.arith = 1'b1;
        eval_d.num   = pa_lo;
        eval_d.den   = pb_lo;
      end
      rfa_pkg::CMD_NEG: begin
        eval_d.arith = 1'b1;
        eval_d.num   = prod_i.short_num;
        eval_d.den   = prod_i.a_den;
      end
      rfa_pkg::CMD_EQ: eval_d.cmp = eq;
      rfa_pkg::CMD_NE: eval_d.cmp = !eq;
      rfa_pkg::CMD_LT: eval_d.cmp = lt;
      rfa_pkg::CMD_GE: eval_d.cmp = !lt;
      rfa_pkg::CMD_GT: eval_d.cmp = gt;
      rfa_pkg::CMD_LE: eval_d.cmp = !gt;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      eval_q <= eval_d;
    end
  end

  assign valid_o = vld_q;
  assign eval_o  = eval_q;

endmodule
`default_nettype wire

/* src/rfa_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_out
// Output stage: replaces a zero arithmetic denominator by one, raises the
// flag and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rfa_out (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire rfa_pkg::eval_t  eval_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rfa_pkg::res_t       res_o
);

  logic          vld_q;
  logic          en;
  logic          den_zero;
  rfa_pkg::res_t res_d, res_q;

  assign en      = !vld_q || ready_i;
  assign ready_o = en;

  // zero denominator fix-up
  assign den_zero = eval_i.arith && (eval_i.den == '0);

  always_comb begin
    res_d.num      = eval_i.num;
    res_d.den      = den_zero ? 32'd1 : eval_i.den;
    res_d.cmp      = eval_i.cmp;
    res_d.den_zero = den_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

/* src/rational_fraction_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path from an accepted transaction to its result on the master side: the input
// register loads at acceptance, then the multiply, evaluate and output registers.
// Throughput: one transaction per cycle; the three 32x32 products each sit in the
// multiply stage with a register after them, and every stage stalls only when full.
// Reset: rst_ni clears all stage valid bits asynchronously; no other state.
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Streaming ALU on unreduced 32-bit fractions: add, sub, mul, div, negate
// and six exact compares, one result per transaction.
// ----------------------------------------------------------------------------
module rational_fraction_alu (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64],
                                           // b_den[127:96]
  input  wire logic [3:0]   s_axis_tuser,  // command[3:0]
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // res_num[31:0], res_den[63:32]
  output logic [1:0]        m_axis_tuser   // cmp_true[0], den_was_zero[1]
);

  logic           in_vld_q;
  logic           in_en;
  rfa_pkg::op_t   op_d, op_q;
  logic           mult_ready;
  logic           mult_valid;
  rfa_pkg::prod_t prod;
  logic           eval_ready;
  logic           eval_valid;
  rfa_pkg::eval_t eval;
  logic           out_ready;
  rfa_pkg::res_t  res;

  // input register
  assign in_en         = !in_vld_q || mult_ready;
  assign s_axis_tready = in_en;

  always_comb begin
    op_d.cmd   = rfa_pkg::cmd_e'(s_axis_tuser);
    op_d.a_num = s_axis_tdata[31:0];
    op_d.a_den = s_axis_tdata[63:32];
    op_d.b_num = s_axis_tdata[95:64];
    op_d.b_den = s_axis_tdata[127:96];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid) begin
      op_q <= op_d;
    end
  end

  // pipeline stages
  rfa_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .ready_o (mult_ready),
    .op_i    (op_q),
    .valid_o (mult_valid),
    .ready_i (eval_ready),
    .prod_o  (prod)
  );

  rfa_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .ready_o (eval_ready),
    .prod_i  (prod),
    .valid_o (eval_valid),
    .ready_i (out_ready),
    .eval_o  (eval)
  );

  rfa_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (eval_valid),
    .ready_o (out_ready),
    .eval_i  (eval),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // master side packing
  assign m_axis_tdata = {res.den, res.num};
  assign m_axis_tuser = {res.den_zero, res.cmp};

endmodule
`default_nettype wire

/* src/rfa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks on the rational fraction ALU result stream.
// ----------------------------------------------------------------------------
module rfa_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // a forced denominator always reads as one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd1)
    else $error("flagged denominator is not one");

  // compare results never carry the zero-denominator flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("compare and zero-denominator flags both set");

  // a true compare gives the fixed 0/1 fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[63:32] == 32'd1)
    else $error("compare result fraction is not 0/1");

  // an empty pipeline takes input in the cycle after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
